@@ rtl/core/isp_pkg.sv @@
package isp_pkg;

    localparam int PIX_W    = 8;
    localparam int CFG_W    = 8;
    localparam int COUNT_W  = 13;

    localparam logic [PIX_W-1:0]   STAR_CHAR = PIX_W'(42);
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    localparam int MAX_COLS_DEF = 128;
    localparam int MAX_ROWS_DEF = 128;

    typedef enum logic {
        CFG_FRAME_ROWS = 1'b0,
        CFG_FRAME_COLS = 1'b1
    } t_cfg_idx;

    // one entry of the column store
    typedef struct packed {
        logic up;    // star bit of this column, row above
        logic cand;  // star still isolated apart from the row below
    } t_col_word;

    typedef struct packed {
        logic star;
        logic has_up;
        logic end_row;
        logic last_row;
    } t_pix_flags;

endpackage

@@ rtl/core/isp_ram.sv @@
module isp_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/isolated_star_pixel_counter.sv @@
// Isolated star pixel counter.
// Pixels enter on i_valid/o_ready in row-major order, one byte per
// transaction; a byte of 42 is a star. frame_rows (index 0) and frame_cols
// (index 1) are set through the write port (i_cfg_we/i_cfg_idx/i_cfg_data)
// while the block is idle; 0 acts as 1 and values above the maximum clamp.
// After the last pixel of a frame one transaction on o_valid/i_ready carries
// the number of stars with no star among their eight neighbours (saturating
// at 8191); other pixels produce nothing.
// Throughput: one pixel per clock while o_ready is high. The count passes
// the compute stage and the output register. The rate is set by the column
// store, a simple dual-port RAM read in the accept cycle and written back
// from the compute stage, with a one-entry bypass for the entry just written.
// While a count waits in the output register pixels keep flowing; only the
// last pixel of the next frame stalls until the receiver takes the count.
// Reset clears position, count and window and marks every column entry as
// clear (one valid flop per column), so no clearing pass is needed. Both
// frame registers reset to 1.
module isolated_star_pixel_counter #(
    parameter int MAX_COLS = isp_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = isp_pkg::MAX_ROWS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_idx,
    input  logic [isp_pkg::CFG_W-1:0]   i_cfg_data,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [isp_pkg::PIX_W-1:0]   i_pixel_char,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [isp_pkg::COUNT_W-1:0] o_star_count
);

    localparam int CW  = $clog2(MAX_COLS);
    localparam int RW  = $clog2(MAX_ROWS);
    localparam int CXW = CW + isp_pkg::CFG_W + 1;
    localparam int RXW = RW + isp_pkg::CFG_W + 1;
    localparam int WW  = $bits(isp_pkg::t_col_word);

    // configuration
    logic [isp_pkg::CFG_W-1:0] r_cfg_rows;
    logic [isp_pkg::CFG_W-1:0] r_cfg_cols;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_rows <= isp_pkg::CFG_W'(1);
            r_cfg_cols <= isp_pkg::CFG_W'(1);
        end else if (i_cfg_we) begin
            case (isp_pkg::t_cfg_idx'(i_cfg_idx))
                isp_pkg::CFG_FRAME_ROWS: r_cfg_rows <= i_cfg_data;
                isp_pkg::CFG_FRAME_COLS: r_cfg_cols <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // accept stage: position and frame edges
    logic [CW-1:0]  r_col;
    logic [RW-1:0]  r_row;
    logic [CXW-1:0] cols_eff;
    logic [RXW-1:0] rows_eff;
    logic           accept;
    isp_pkg::t_pix_flags s0_flags;

    always_comb begin
        if (r_cfg_cols == '0) begin
            cols_eff = CXW'(1);
        end else if (CXW'(r_cfg_cols) > CXW'(MAX_COLS)) begin
            cols_eff = CXW'(MAX_COLS);
        end else begin
            cols_eff = CXW'(r_cfg_cols);
        end
        if (r_cfg_rows == '0) begin
            rows_eff = RXW'(1);
        end else if (RXW'(r_cfg_rows) > RXW'(MAX_ROWS)) begin
            rows_eff = RXW'(MAX_ROWS);
        end else begin
            rows_eff = RXW'(r_cfg_rows);
        end
        s0_flags.star     = (i_pixel_char == isp_pkg::STAR_CHAR);
        s0_flags.has_up   = (r_row != '0);
        s0_flags.end_row  = (CXW'(r_col) + CXW'(1)) >= cols_eff;
        s0_flags.last_row = (RXW'(r_row) + RXW'(1)) >= rows_eff;
    end

    assign accept = i_valid & o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            if (s0_flags.end_row) begin
                r_col <= '0;
                r_row <= s0_flags.last_row ? '0 : r_row + RW'(1);
            end else begin
                r_col <= r_col + CW'(1);
            end
        end
    end

    // compute stage
    logic                r_s1_v;
    logic [CW-1:0]       r_s1_col;
    isp_pkg::t_pix_flags r_s1;
    logic                s1_emit;
    logic                s1_fire;

    logic r_left, r_left2, r_up1, r_up2, r_cand_prev;
    logic [isp_pkg::COUNT_W-1:0] r_count;
    logic [isp_pkg::COUNT_W-1:0] count_sat;
    logic [isp_pkg::COUNT_W:0]   count_sum;
    logic [2:0]                  n_inc;

    logic                 r_out_v;
    logic [isp_pkg::COUNT_W-1:0] r_out_data;

    // column store, bypass and valid bits
    logic [MAX_COLS-1:0]  r_vld;
    logic                 r_vld_q;
    logic                 r_byp_v;
    isp_pkg::t_col_word   r_byp_word;
    logic [WW-1:0]        ram_q;
    isp_pkg::t_col_word   rd_word;

    logic                 r_pend_v;
    logic [CW-1:0]        r_pend_addr;
    isp_pkg::t_col_word   r_pend_word;
    logic                 n_pend_v;
    logic [CW-1:0]        n_pend_addr;
    isp_pkg::t_col_word   n_pend_word;

    logic                 item_we;
    logic [CW-1:0]        item_addr;
    isp_pkg::t_col_word   item_word;
    logic                 pend_create;
    logic                 pend_flush;
    logic                 wr_en;
    logic [CW-1:0]        wr_addr;
    isp_pkg::t_col_word   wr_word;

    logic col_nz, above, nc_left, nc_here;
    logic inc_ul, inc_left, inc_up, inc_here;

    assign s1_emit = r_s1.end_row & r_s1.last_row;
    assign s1_fire = r_s1_v & (~s1_emit | ~r_out_v | i_ready);
    assign o_ready = ~r_s1_v | s1_fire;

    always_comb begin
        if (r_byp_v) begin
            rd_word = r_byp_word;
        end else if (r_vld_q) begin
            rd_word = isp_pkg::t_col_word'(ram_q);
        end else begin
            rd_word = '0;
        end

        col_nz   = (r_s1_col != '0);
        above    = r_s1.has_up & rd_word.up;
        // pixel above-left closes, and the pixel to the left gets its flag
        nc_left  = r_left & ~r_up2 & ~r_up1 & ~above & ~r_left2 & ~r_s1.star;
        inc_ul   = col_nz & r_s1.has_up & r_cand_prev & ~r_left2 & ~r_left & ~r_s1.star;
        inc_left = col_nz & r_s1.last_row & nc_left;
        // right edge: pixel above and this pixel close
        nc_here  = r_s1.star & ~r_up1 & ~above & ~r_left;
        inc_up   = r_s1.end_row & r_s1.has_up & rd_word.cand & ~r_left & ~r_s1.star;
        inc_here = r_s1.end_row & r_s1.last_row & nc_here;

        n_inc     = 3'({2'b0, inc_ul}) + 3'({2'b0, inc_left})
                  + 3'({2'b0, inc_up}) + 3'({2'b0, inc_here});
        count_sum = {1'b0, r_count} + (isp_pkg::COUNT_W + 1)'(n_inc);
        count_sat = (count_sum > {1'b0, isp_pkg::COUNT_MAX}) ? isp_pkg::COUNT_MAX
                                                            : count_sum[isp_pkg::COUNT_W-1:0];
    end

    // write-back: the entry left of each pixel as it leaves the compute stage; at a row end the
    // entry of the last column waits in a one-entry pending slot
    always_comb begin
        item_we   = s1_fire & (col_nz | r_s1.end_row);
        item_addr = col_nz ? r_s1_col - CW'(1) : '0;
        item_word = col_nz ? isp_pkg::t_col_word'{up: r_left, cand: nc_left}
                           : isp_pkg::t_col_word'{up: r_s1.star, cand: nc_here};

        pend_create = s1_fire & r_s1.end_row & col_nz;
        pend_flush  = ~item_we & r_pend_v;

        wr_en   = item_we | r_pend_v;
        wr_addr = item_we ? item_addr : r_pend_addr;
        wr_word = item_we ? item_word : r_pend_word;

        n_pend_v    = pend_create | (r_pend_v & ~pend_flush);
        n_pend_addr = pend_create ? r_s1_col : r_pend_addr;
        n_pend_word = pend_create ? isp_pkg::t_col_word'{up: r_s1.star, cand: nc_here}
                                  : r_pend_word;
    end

    isp_ram #(
        .WIDTH (WW),
        .DEPTH (MAX_COLS)
    ) u_col_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (WW'(wr_word)),
        .i_re    (accept),
        .i_raddr (r_col),
        .o_rdata (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_pend_v <= 1'b0;
            r_byp_v  <= 1'b0;
        end else begin
            if (wr_en) begin
                r_vld[wr_addr] <= 1'b1;
            end
            r_pend_v <= n_pend_v;
            if (accept) begin
                r_byp_v <= (wr_en & (wr_addr == r_col)) | (n_pend_v & (n_pend_addr == r_col));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_addr <= n_pend_addr;
        r_pend_word <= n_pend_word;
        if (accept) begin
            r_vld_q    <= r_vld[r_col];
            r_byp_word <= (wr_en & (wr_addr == r_col)) ? wr_word : n_pend_word;
            r_s1_col   <= r_col;
            r_s1       <= s0_flags;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v      <= 1'b0;
            r_left      <= 1'b0;
            r_left2     <= 1'b0;
            r_up1       <= 1'b0;
            r_up2       <= 1'b0;
            r_cand_prev <= 1'b0;
            r_count     <= '0;
            r_out_v     <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_v <= 1'b1;
            end else if (s1_fire) begin
                r_s1_v <= 1'b0;
            end

            if (s1_fire) begin
                if (r_s1.end_row) begin
                    r_left  <= 1'b0;
                    r_left2 <= 1'b0;
                    r_up1   <= 1'b0;
                    r_up2   <= 1'b0;
                end else begin
                    r_left  <= r_s1.star;
                    r_left2 <= r_left;
                    r_up1   <= above;
                    r_up2   <= r_up1;
                end
                r_cand_prev <= rd_word.cand;
                r_count     <= s1_emit ? '0 : count_sat;
            end

            if (s1_fire & s1_emit) begin
                r_out_v <= 1'b1;
            end else if (i_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire & s1_emit) begin
            r_out_data <= count_sat;
        end
    end

    assign o_valid      = r_out_v;
    assign o_star_count = r_out_data;

    // a new pending write never finds the slot still occupied
    a_pend_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(pend_create && r_pend_v))
        else $error("pending column write overwritten");

    // a count appears only after the last pixel of a frame went through
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_v) |-> $past(s1_fire && s1_emit))
        else $error("count raised without a frame end");

    // the column position stays inside the store
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (CXW'(r_col) < CXW'(MAX_COLS)))
        else $error("column position out of range");

endmodule

@@ sim/tb.sv @@
module tb;

    localparam int MAX_COLS     = isp_pkg::MAX_COLS_DEF;
    localparam int MAX_ROWS     = isp_pkg::MAX_ROWS_DEF;
    localparam int ITEMS        = 1450;
    localparam int IDLE_PCT     = 29;
    localparam int DRAIN_CYCLES = 4;
    localparam int HOLD_CYCLES  = 400;
    localparam logic [isp_pkg::PIX_W-1:0] DOT_CHAR = isp_pkg::PIX_W'(46);

    logic                        i_clk;
    logic                        i_rst_n      = 1'b0;
    logic                        i_cfg_we     = 1'b0;
    logic                        i_cfg_idx    = isp_pkg::CFG_FRAME_ROWS;
    logic [isp_pkg::CFG_W-1:0]   i_cfg_data   = '0;
    logic                        i_valid      = 1'b0;
    logic                        o_ready;
    logic [isp_pkg::PIX_W-1:0]   i_pixel_char = '0;
    logic                        o_valid;
    logic                        i_ready      = 1'b0;
    logic [isp_pkg::COUNT_W-1:0] o_star_count;

    isolated_star_pixel_counter dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_pixel_char (i_pixel_char),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_star_count (o_star_count)
    );

    // pixels waiting to be driven, and frame counts still owed by the block
    logic [isp_pkg::PIX_W-1:0]   pix_q[$];
    logic [isp_pkg::COUNT_W-1:0] exp_counts[$];

    // shadow of the block: frame registers, column store, window and position
    logic [isp_pkg::CFG_W-1:0]   reg_rows = isp_pkg::CFG_W'(1);
    logic [isp_pkg::CFG_W-1:0]   reg_cols = isp_pkg::CFG_W'(1);
    bit                          up_star[MAX_COLS];
    bit                          cand_star[MAX_COLS];
    bit                          win_l1, win_l2, win_u1, win_u2;
    int unsigned                 pos_row, pos_col;
    logic [isp_pkg::COUNT_W-1:0] iso_total = '0;

    bit                          px_fire;
    bit                          calm;
    bit                          hold_req;
    int                          hold_left;
    int                          n_err, n_pushed, n_pixels, n_frames, n_cfg;
    logic [isp_pkg::COUNT_W-1:0] want, got_cnt;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int clamp_dim(input int v, input int hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic void flag_error(input string msg);
        n_err++;
        if (n_err <= 10) $display("ERROR at %0t: %s", $time, msg);
    endfunction

    function automatic void bump_iso(input bit hit);
        if (hit && iso_total != isp_pkg::COUNT_MAX) iso_total++;
    endfunction

    // Advance the shadow by one pixel; returns 1 with the frame total on the
    // last pixel of a frame.
    function automatic bit step_isolated_count(input logic [isp_pkg::PIX_W-1:0] px,
                                               output logic [isp_pkg::COUNT_W-1:0] total);
        int unsigned n_rows, n_cols, c, r;
        bit s, has_up, end_row, last_row, above, fresh;
        n_rows   = clamp_dim(reg_rows, MAX_ROWS);
        n_cols   = clamp_dim(reg_cols, MAX_COLS);
        c        = (pos_col >= MAX_COLS) ? MAX_COLS - 1 : pos_col;
        r        = pos_row;
        s        = (px == isp_pkg::STAR_CHAR);
        has_up   = r > 0;
        end_row  = c + 1 >= n_cols;
        last_row = r + 1 >= n_rows;
        above    = has_up && up_star[c];
        up_star[c] = s;
        total    = '0;
        // above-left pixel now has its whole neighbourhood
        if (c > 0) begin
            if (has_up) bump_iso(cand_star[c-1] && !win_l2 && !win_l1 && !s);
            fresh = win_l1 && !win_u2 && !win_u1 && !above && !win_l2 && !s;
            cand_star[c-1] = fresh;
            if (last_row) bump_iso(fresh);
        end
        // right edge closes the pixel above and this one
        if (end_row) begin
            if (has_up) bump_iso(cand_star[c] && !win_l1 && !s);
            fresh = s && !win_u1 && !above && !win_l1;
            cand_star[c] = fresh;
            if (last_row) bump_iso(fresh);
        end
        win_u2  = win_u1;
        win_u1  = above;
        win_l2  = win_l1;
        win_l1  = s;
        pos_col = c + 1;
        if (end_row) begin
            win_u1  = 1'b0;
            win_u2  = 1'b0;
            win_l1  = 1'b0;
            win_l2  = 1'b0;
            pos_col = 0;
            pos_row = r + 1;
            if (last_row) begin
                total     = iso_total;
                iso_total = '0;
                pos_row   = 0;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // pixel driver
    always @(negedge i_clk) begin
        if (!i_valid || px_fire) begin
            if (pix_q.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
                i_valid      <= 1'b1;
                i_pixel_char <= pix_q.pop_front();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // count receiver, with an occasional long hold-off
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // monitor: check counts, track register writes, predict from accepted pixels
    always @(posedge i_clk) begin
        px_fire = i_rst_n && i_valid && o_ready;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                n_frames++;
                if (exp_counts.size() == 0) begin
                    flag_error($sformatf("count %0d with no frame outstanding",
                                         o_star_count));
                end else begin
                    want = exp_counts.pop_front();
                    if (o_star_count !== want)
                        flag_error($sformatf("star count: expected %0d, got %0d",
                                             want, o_star_count));
                end
            end
            if (i_cfg_we) begin
                if (i_cfg_idx == isp_pkg::CFG_FRAME_ROWS) reg_rows = i_cfg_data;
                else reg_cols = i_cfg_data;
            end
            if (px_fire) begin
                n_pixels++;
                if (step_isolated_count(i_pixel_char, got_cnt)) exp_counts.push_back(got_cnt);
            end
        end
    end

    task automatic wait_idle();
        while (n_pixels != n_pushed || exp_counts.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_dims(input int rows_v, input int cols_v);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= isp_pkg::CFG_FRAME_ROWS;
        i_cfg_data <= isp_pkg::CFG_W'(rows_v);
        @(negedge i_clk);
        i_cfg_idx  <= isp_pkg::CFG_FRAME_COLS;
        i_cfg_data <= isp_pkg::CFG_W'(cols_v);
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        @(posedge i_clk);
        n_cfg += 2;
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            pix_q.push_back(isp_pkg::PIX_W'(s[i]));
            n_pushed++;
        end
    endtask

    task automatic push_pixels(input int n, input int dens);
        logic [isp_pkg::PIX_W-1:0] px;
        repeat (n) begin
            if ($urandom_range(99) < dens) px = isp_pkg::STAR_CHAR;
            else if ($urandom_range(99) < 70) px = DOT_CHAR;
            else px = isp_pkg::PIX_W'($urandom_range(255));
            pix_q.push_back(px);
            n_pushed++;
        end
    endtask

    initial begin
        int  rows_w, cols_w, eff, frames, dens, kind;
        bit  pressed;
        pressed = 1'b0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset geometry is one pixel per frame
        push_text("*.");
        pix_q.push_back(8'h00);
        pix_q.push_back(8'hFF);
        n_pushed += 2;
        wait_idle();

        // corner stars with nothing around them, outside the frame counts as clear
        set_dims(3, 3);
        push_text("*.*...*.*");
        wait_idle();

        // shrink the frame half way through a row, then end it early
        set_dims(3, 6);
        push_text("*.*.*.*.");
        wait_idle();
        set_dims(2, 3);
        push_text("*");
        wait_idle();

        // out-of-range register values: 0 acts as 1, large values clamp
        set_dims(0, 255);
        push_pixels(128, 20);
        wait_idle();
        set_dims(255, 0);
        push_pixels(128, 20);

        while (n_pushed < ITEMS) begin
            wait_idle();
            calm = (n_pushed >= 750 && n_pushed < 1000);
            if (!pressed && n_pushed >= 450) begin
                // receiver stalls while several frames are offered
                set_dims(2, 3);
                hold_req = 1'b1;
                push_pixels(36, 30);
                pressed = 1'b1;
                continue;
            end
            kind = $urandom_range(99);
            if (kind < 5) begin
                if ($urandom_range(1)) begin
                    rows_w = $urandom_range(1) ? 128 : $urandom_range(129, 255);
                    cols_w = $urandom_range(0, 2);
                end else begin
                    rows_w = $urandom_range(0, 2);
                    cols_w = $urandom_range(1) ? 128 : $urandom_range(129, 255);
                end
            end else if (kind < 25) begin
                rows_w = $urandom_range(0, 16);
                cols_w = $urandom_range(0, 16);
            end else begin
                rows_w = $urandom_range(1, 6);
                cols_w = $urandom_range(1, 6);
            end
            set_dims(rows_w, cols_w);
            eff    = clamp_dim(rows_w, MAX_ROWS) * clamp_dim(cols_w, MAX_COLS);
            frames = (eff > 64) ? 1 : $urandom_range(1, 4);
            dens   = $urandom_range(5, 50);
            // now and then a broken frame, left for the next geometry to finish
            if ($urandom_range(99) < 12) push_pixels($urandom_range(1, eff * frames), dens);
            else push_pixels(eff * frames, dens);
        end
        calm = 1'b0;

        wait_idle();
        repeat (8) @(posedge i_clk);
        if (exp_counts.size() != 0)
            flag_error($sformatf("%0d frame counts never arrived", exp_counts.size()));
        $display("Covered %0d pixels and %0d frame counts over %0d register writes,",
                 n_pixels, n_frames, n_cfg);
        $display("including clamped sizes, mid-frame resizing and a long output stall.");
        if (n_err == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/isp_pkg.sv
rtl/core/isp_ram.sv
rtl/core/isolated_star_pixel_counter.sv
sim/tb.sv
